[design/ktsm_pkg.sv]
// ----------------------------------------------------------------------------
// ktsm_pkg
// Types, constants and helpers shared by the keyword table matcher.
// ----------------------------------------------------------------------------
package ktsm_pkg;

    localparam int TABLE_SLOTS = 16;
    localparam int SLOT_CHARS  = 32;
    localparam int KW_MAX      = SLOT_CHARS - 1;
    localparam int LIMIT_W     = 5;

    localparam int SLOT_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int COUNT_W = $clog2(TABLE_SLOTS + 1);
    localparam int POS_W   = $clog2(SLOT_CHARS + 1);
    localparam int LEN_W   = $clog2(SLOT_CHARS);
    localparam int CIDX_W  = (KW_MAX > 1) ? $clog2(KW_MAX) : 1;
    localparam int CNT_W   = (LEN_W > LIMIT_W) ? LEN_W : LIMIT_W;

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_SCAN   = 2'd2,
        KIND_NONE   = 2'd3
    } ktsm_kind_t;

    typedef enum logic [2:0] {
        RS_ADDED     = 3'd0,
        RS_DUPLICATE = 3'd1,
        RS_FULL      = 3'd2,
        RS_EMPTY     = 3'd3,
        RS_REMOVED   = 3'd4,
        RS_NOT_FOUND = 3'd5,
        RS_MATCH     = 3'd6,
        RS_NO_MATCH  = 3'd7
    } ktsm_status_t;

    typedef enum logic [1:0] {
        RD_IDX,
        RD_NEXT,
        RD_FOUND
    } ktsm_rd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHR_RD,
        S_CHR_UPD,
        S_POST,
        S_FIND,
        S_MV_RD,
        S_MV_WR,
        S_MV_END,
        S_RP_RD,
        S_EMIT
    } ktsm_state_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic       no_char;
        logic       last;
    } ktsm_in_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] out_char;
        logic       out_last;
    } ktsm_out_t;

    typedef struct packed {
        logic         accept;
        logic         idx_clr;
        logic         idx_inc;
        logic         rd_en;
        ktsm_rd_t     rd_sel;
        logic         upd_slot;
        logic         pos_inc;
        logic         clear;
        logic         add_slot;
        logic         set_found;
        logic         mv_wr;
        logic         mv_end;
        logic         k_clr;
        logic         k_inc;
        logic         emit;
        ktsm_status_t emit_status;
        logic         emit_char;
        logic         emit_last;
    } ktsm_cmd_t;

    typedef struct packed {
        logic       in_take;
        ktsm_kind_t kind;
        logic       last;
        logic       idx_end;
        logic       pos_zero;
        logic       full;
        logic       eq_at;
        logic       hit_at;
        logic       mv_done;
        logic       cnt_zero;
        logic       k_last;
    } ktsm_stat_t;

    function automatic logic [7:0] fold_char(input logic [7:0] c);
        fold_char = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

endpackage

[design/ktsm_ctrl.sv]
// ----------------------------------------------------------------------------
// ktsm_ctrl
// Sequencer for the keyword table matcher: steps the datapath through the
// per-character slot sweep, the final search, compaction and reply.
// ----------------------------------------------------------------------------
module ktsm_ctrl import ktsm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  ktsm_stat_t stat,
    output logic       busy,
    output ktsm_cmd_t  cmd
);

    ktsm_state_t state_reg;
    ktsm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = stat.in_take ? S_CHR_RD : S_POST;
                end
            end
            S_CHR_RD:
            begin
                state_next = stat.idx_end ? S_POST : S_CHR_UPD;
            end
            S_CHR_UPD:
            begin
                state_next = S_CHR_RD;
            end
            S_POST:
            begin
                if (!stat.last || stat.kind == KIND_NONE)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.kind == KIND_ADD && stat.pos_zero)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_FIND;
                end
            end
            S_FIND:
            begin
                if (stat.idx_end)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.kind != KIND_SCAN && stat.eq_at)
                begin
                    state_next = (stat.kind == KIND_REMOVE) ? S_MV_RD : S_IDLE;
                end
                else if (stat.kind == KIND_SCAN && stat.hit_at)
                begin
                    state_next = S_RP_RD;
                end
            end
            S_MV_RD:
            begin
                state_next = stat.mv_done ? S_MV_END : S_MV_WR;
            end
            S_MV_WR:
            begin
                state_next = S_MV_RD;
            end
            S_MV_END:
            begin
                state_next = S_IDLE;
            end
            S_RP_RD:
            begin
                state_next = stat.cnt_zero ? S_IDLE : S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.k_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.accept  = 1'b1;
                    cmd.idx_clr = 1'b1;
                end
            end
            S_CHR_RD:
            begin
                if (stat.idx_end)
                begin
                    cmd.pos_inc = 1'b1;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_IDX;
                end
            end
            S_CHR_UPD:
            begin
                cmd.upd_slot = 1'b1;
                cmd.idx_inc  = 1'b1;
            end
            S_POST:
            begin
                if (stat.last && stat.kind == KIND_NONE)
                begin
                    cmd.clear = 1'b1;
                end
                else if (stat.last && stat.kind == KIND_ADD && stat.pos_zero)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = RS_EMPTY;
                    cmd.emit_last   = 1'b1;
                    cmd.clear       = 1'b1;
                end
                else
                begin
                    cmd.idx_clr = 1'b1;
                end
            end
            S_FIND:
            begin
                if (stat.idx_end)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    cmd.clear     = 1'b1;
                    if (stat.kind == KIND_ADD)
                    begin
                        cmd.emit_status = stat.full ? RS_FULL : RS_ADDED;
                        cmd.add_slot    = !stat.full;
                    end
                    else if (stat.kind == KIND_REMOVE)
                    begin
                        cmd.emit_status = RS_NOT_FOUND;
                    end
                    else
                    begin
                        cmd.emit_status = RS_NO_MATCH;
                    end
                end
                else if (stat.kind != KIND_SCAN && stat.eq_at)
                begin
                    if (stat.kind == KIND_REMOVE)
                    begin
                        cmd.set_found = 1'b1;
                    end
                    else
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = RS_DUPLICATE;
                        cmd.emit_last   = 1'b1;
                        cmd.clear       = 1'b1;
                    end
                end
                else if (stat.kind == KIND_SCAN && stat.hit_at)
                begin
                    cmd.set_found = 1'b1;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_MV_RD:
            begin
                if (!stat.mv_done)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_NEXT;
                end
            end
            S_MV_WR:
            begin
                cmd.mv_wr   = 1'b1;
                cmd.idx_inc = 1'b1;
            end
            S_MV_END:
            begin
                cmd.mv_end      = 1'b1;
                cmd.emit        = 1'b1;
                cmd.emit_status = RS_REMOVED;
                cmd.emit_last   = 1'b1;
                cmd.clear       = 1'b1;
            end
            S_RP_RD:
            begin
                if (stat.cnt_zero)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = RS_MATCH;
                    cmd.emit_last   = 1'b1;
                    cmd.clear       = 1'b1;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_FOUND;
                    cmd.k_clr  = 1'b1;
                end
            end
            S_EMIT:
            begin
                cmd.emit        = 1'b1;
                cmd.emit_status = RS_MATCH;
                cmd.emit_char   = 1'b1;
                cmd.emit_last   = stat.k_last;
                cmd.k_inc       = 1'b1;
                cmd.clear       = stat.k_last;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

[design/ktsm_dp.sv]
// ----------------------------------------------------------------------------
// ktsm_dp
// Datapath: keyword row memory, per-slot match state, table bookkeeping and
// the result register.
// ----------------------------------------------------------------------------
module ktsm_dp import ktsm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ktsm_in_t             item,
    input  logic                 cfg_we,
    input  logic [LIMIT_W-1:0]   cfg_data,
    input  ktsm_cmd_t            cmd,
    output ktsm_stat_t           stat,
    output logic                 result_valid,
    output ktsm_out_t            result
);

    logic [KW_MAX-1:0][7:0] mem [TABLE_SLOTS];
    logic [KW_MAX-1:0][7:0] rdata_reg;

    ktsm_kind_t             kind_reg;
    logic                   last_reg;
    logic [7:0]             ch_reg;
    logic [POS_W-1:0]       pos_reg;
    logic [COUNT_W-1:0]     count_reg;
    logic [COUNT_W-1:0]     idx_reg;
    logic [SLOT_W-1:0]      found_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W-1:0]       k_reg;
    logic [LIMIT_W-1:0]     limit_reg;
    logic [TABLE_SLOTS-1:0] eq_reg;
    logic [TABLE_SLOTS-1:0] hit_reg;
    logic [KW_MAX-1:0]      pm_reg [TABLE_SLOTS];
    logic [LEN_W-1:0]       len_reg [TABLE_SLOTS];
    logic                   res_valid_reg;
    ktsm_out_t              res_reg;

    logic [SLOT_W-1:0]      si;
    logic [COUNT_W-1:0]     idx_plus;
    logic [SLOT_W-1:0]      rd_addr;
    logic                   wr_char;
    logic [7:0]             fc;
    logic [LEN_W-1:0]       cur_len;
    logic [KW_MAX-1:0]      old_sh;
    logic [KW_MAX-1:0]      nb;
    logic                   eq_new;
    logic                   hit_new;
    logic [LEN_W-1:0]       add_len;
    logic [CNT_W-1:0]       len_ext;
    logic [CNT_W-1:0]       lim_ext;
    logic [CIDX_W-1:0]      kidx;
    logic                   in_take;

    assign si       = idx_reg[SLOT_W-1:0];
    assign idx_plus = idx_reg + COUNT_W'(1);
    assign kidx     = k_reg[CIDX_W-1:0];
    assign in_take  = !item.no_char && (item.ch != 8'd0);
    assign wr_char  = cmd.accept && in_take && (count_reg < COUNT_W'(TABLE_SLOTS))
                      && (pos_reg < POS_W'(KW_MAX));
    assign add_len  = (pos_reg < POS_W'(KW_MAX)) ? LEN_W'(pos_reg) : LEN_W'(KW_MAX);
    assign len_ext  = CNT_W'(len_reg[si]);
    assign lim_ext  = CNT_W'(limit_reg);

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_IDX:   rd_addr = si;
            RD_NEXT:  rd_addr = idx_plus[SLOT_W-1:0];
            RD_FOUND: rd_addr = found_reg;
            default:  rd_addr = si;
        endcase
    end

    always_comb
    begin
        fc      = fold_char(ch_reg);
        cur_len = len_reg[si];
        old_sh  = (pm_reg[si] << 1) | KW_MAX'(1);
        for (int j = 0; j < KW_MAX; j++)
        begin
            nb[j] = (LEN_W'(j) < cur_len) && old_sh[j] && (fold_char(rdata_reg[j]) == fc);
        end
        eq_new  = eq_reg[si] && (pos_reg < POS_W'(cur_len))
                  && (fold_char(rdata_reg[pos_reg[CIDX_W-1:0]]) == fc);
        hit_new = hit_reg[si] || ((cur_len != '0) && nb[cur_len - LEN_W'(1)]);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mv_wr)
        begin
            mem[si] <= rdata_reg;
        end
        else if (wr_char)
        begin
            mem[count_reg[SLOT_W-1:0]][pos_reg[CIDX_W-1:0]] <= item.ch;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
        if (cmd.accept)
        begin
            ch_reg <= item.ch;
        end
        if (cmd.emit)
        begin
            res_reg.status   <= cmd.emit_status;
            res_reg.out_char <= cmd.emit_char ? rdata_reg[kidx] : 8'd0;
            res_reg.out_last <= cmd.emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg      <= KIND_ADD;
            last_reg      <= 1'b0;
            pos_reg       <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            found_reg     <= '0;
            cnt_reg       <= '0;
            k_reg         <= '0;
            limit_reg     <= LIMIT_W'(31);
            eq_reg        <= '1;
            hit_reg       <= '0;
            res_valid_reg <= 1'b0;
            for (int s = 0; s < TABLE_SLOTS; s++)
            begin
                pm_reg[s]  <= '0;
                len_reg[s] <= '0;
            end
        end
        else
        begin
            res_valid_reg <= cmd.emit;
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
            if (cmd.accept)
            begin
                kind_reg <= ktsm_kind_t'(item.kind);
                last_reg <= item.last;
            end
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_plus;
            end
            if (cmd.set_found)
            begin
                found_reg <= si;
                cnt_reg   <= (lim_ext < len_ext) ? lim_ext : len_ext;
            end
            if (cmd.k_clr)
            begin
                k_reg <= '0;
            end
            else if (cmd.k_inc)
            begin
                k_reg <= k_reg + CNT_W'(1);
            end
            if (cmd.clear)
            begin
                eq_reg  <= '1;
                hit_reg <= '0;
                pos_reg <= '0;
                for (int s = 0; s < TABLE_SLOTS; s++)
                begin
                    pm_reg[s] <= '0;
                end
            end
            else
            begin
                if (cmd.upd_slot)
                begin
                    eq_reg[si]  <= eq_new;
                    hit_reg[si] <= hit_new;
                    pm_reg[si]  <= nb;
                end
                if (cmd.pos_inc && pos_reg < POS_W'(SLOT_CHARS))
                begin
                    pos_reg <= pos_reg + POS_W'(1);
                end
            end
            if (cmd.add_slot)
            begin
                len_reg[count_reg[SLOT_W-1:0]] <= add_len;
                count_reg <= count_reg + COUNT_W'(1);
            end
            else if (cmd.mv_end)
            begin
                for (int s = 0; s < TABLE_SLOTS - 1; s++)
                begin
                    if (SLOT_W'(s) >= found_reg)
                    begin
                        len_reg[s] <= len_reg[s + 1];
                    end
                end
                len_reg[TABLE_SLOTS - 1] <= '0;
                count_reg <= count_reg - COUNT_W'(1);
            end
        end
    end

    always_comb
    begin
        stat          = '0;
        stat.in_take  = in_take;
        stat.kind     = kind_reg;
        stat.last     = last_reg;
        stat.idx_end  = (idx_reg == count_reg);
        stat.pos_zero = (pos_reg == '0);
        stat.full     = (count_reg >= COUNT_W'(TABLE_SLOTS));
        stat.eq_at    = eq_reg[si] && (POS_W'(len_reg[si]) == pos_reg);
        stat.hit_at   = hit_reg[si];
        stat.mv_done  = ({1'b0, idx_plus} >= {1'b0, count_reg});
        stat.cnt_zero = (cnt_reg == '0);
        stat.k_last   = ({1'b0, k_reg} + (CNT_W + 1)'(1) == {1'b0, cnt_reg});
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    a_burst_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_reg.out_last |=> res_valid_reg)
        else $error("match reply broken before its last item");

    a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mv_end |=> count_reg == $past(count_reg) - COUNT_W'(1))
        else $error("remove did not shrink the table by one");

    a_add_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.add_slot |-> count_reg < COUNT_W'(TABLE_SLOTS))
        else $error("keyword stored into a full table");

    a_clear_word: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> pos_reg == '0 && hit_reg == '0 && eq_reg == '1)
        else $error("word state not cleared");

endmodule

[design/keyword_table_substring_matcher.sv]
// ----------------------------------------------------------------------------
// keyword_table_substring_matcher
// Ordered keyword table with add, remove and case-insensitive text scan.
// ----------------------------------------------------------------------------
// A character item takes one row read and one update per stored keyword.
// A final item adds a search over the slots.
// A remove adds a row read and a row write per keyword moved down; a match reply adds one row read
// and then one result per cycle, which the receiver cannot stall.
// Reset empties the table and sets the reply limit to 31; no clearing pass is needed.
module keyword_table_substring_matcher import ktsm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  ktsm_in_t           item,
    output logic               result_valid,
    output ktsm_out_t          result,
    input  logic               cfg_we,
    input  logic [LIMIT_W-1:0] cfg_data
);

    ktsm_cmd_t  cmd;
    ktsm_stat_t stat;

    ktsm_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    ktsm_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

[tb/tb_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_checker
// Watches the item and result channels of the keyword table matcher, keeps
// its own copy of the keyword table and scan state, and compares each result
// item with the oldest expected one.
// ----------------------------------------------------------------------------
module tb_checker import ktsm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  ktsm_in_t           item,
    input  logic               result_valid,
    input  ktsm_out_t          result,
    input  logic               cfg_we,
    input  logic [LIMIT_W-1:0] cfg_data,
    output int                 fail_count,
    output int                 pending
);

    logic [7:0]        kw_text [TABLE_SLOTS][KW_MAX];
    int                kw_len [TABLE_SLOTS];
    int                kw_count;
    bit                eq_run [TABLE_SLOTS];
    bit [KW_MAX-1:0]   prefix_hits [TABLE_SLOTS];
    bit                found [TABLE_SLOTS];
    int                word_pos;
    logic [LIMIT_W-1:0] limit;
    ktsm_out_t         replies [$];

    assign pending = replies.size();

    function automatic logic [7:0] lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    task automatic reset_word();
        for (int s = 0; s < TABLE_SLOTS; s++)
        begin
            eq_run[s] = 1;
            prefix_hits[s] = '0;
            found[s] = 0;
        end
        word_pos = 0;
    endtask

    task automatic take_char(input logic [7:0] c);
        bit [KW_MAX-1:0] nb;
        bit prev;
        for (int s = 0; s < kw_count; s++)
        begin
            nb = '0;
            if (!(word_pos < kw_len[s] && lower(kw_text[s][word_pos]) == lower(c)))
                eq_run[s] = 0;
            for (int j = 0; j < kw_len[s]; j++)
            begin
                prev = (j == 0) ? 1'b1 : prefix_hits[s][j-1];
                if (prev && lower(kw_text[s][j]) == lower(c))
                    nb[j] = 1;
            end
            prefix_hits[s] = nb;
            if (kw_len[s] > 0 && nb[kw_len[s]-1])
                found[s] = 1;
        end
        if (kw_count < TABLE_SLOTS && word_pos < KW_MAX)
            kw_text[kw_count][word_pos] = c;
        if (word_pos < SLOT_CHARS)
            word_pos++;
    endtask

    function automatic int equal_slot();
        for (int s = 0; s < kw_count; s++)
            if (eq_run[s] && kw_len[s] == word_pos)
                return s;
        return -1;
    endfunction

    task automatic push_status(input ktsm_status_t st);
        replies.push_back('{status: st, out_char: 8'd0, out_last: 1'b1});
    endtask

    task automatic predict_item(input ktsm_in_t it);
        int f;
        int n;
        if (!it.no_char && it.ch != 0)
            take_char(it.ch);
        if (!it.last)
            return;
        case (ktsm_kind_t'(it.kind))
            KIND_ADD:
            begin
                if (word_pos == 0)
                    push_status(RS_EMPTY);
                else if (equal_slot() >= 0)
                    push_status(RS_DUPLICATE);
                else if (kw_count >= TABLE_SLOTS)
                    push_status(RS_FULL);
                else
                begin
                    kw_len[kw_count] = (word_pos < KW_MAX) ? word_pos : KW_MAX;
                    kw_count++;
                    push_status(RS_ADDED);
                end
            end
            KIND_REMOVE:
            begin
                f = equal_slot();
                if (f < 0)
                    push_status(RS_NOT_FOUND);
                else
                begin
                    for (int s = f; s + 1 < kw_count; s++)
                    begin
                        kw_text[s] = kw_text[s+1];
                        kw_len[s] = kw_len[s+1];
                    end
                    kw_count--;
                    kw_len[kw_count] = 0;
                    push_status(RS_REMOVED);
                end
            end
            KIND_SCAN:
            begin
                f = -1;
                for (int s = kw_count - 1; s >= 0; s--)
                    if (found[s])
                        f = s;
                if (f < 0)
                    push_status(RS_NO_MATCH);
                else
                begin
                    n = (kw_len[f] < limit) ? kw_len[f] : limit;
                    if (n == 0)
                        push_status(RS_MATCH);
                    for (int k = 0; k < n; k++)
                        replies.push_back('{status: RS_MATCH, out_char: kw_text[f][k],
                                            out_last: (k + 1 == n)});
                end
            end
            default: ;
        endcase
        reset_word();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        ktsm_out_t exp_r;
        if (!rst_n)
        begin
            kw_count = 0;
            limit = 5'd31;
            for (int s = 0; s < TABLE_SLOTS; s++)
                kw_len[s] = 0;
            reset_word();
            replies.delete();
            fail_count = 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (replies.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("Unexpected result item %p", result);
                end
                else
                begin
                    exp_r = replies.pop_front();
                    if (exp_r.status !== result.status || exp_r.out_char !== result.out_char
                        || exp_r.out_last !== result.out_last)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("Mismatch: expected %p, got %p", exp_r, result);
                    end
                end
            end
            if (cfg_we)
                limit = cfg_data;
            if (start && !busy)
                predict_item(item);
        end
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives words and texts into the keyword table matcher, with bursts and
// gaps, across several reply limits, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_top;
    import ktsm_pkg::*;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               start = 0;
    logic               busy;
    ktsm_in_t           item = '0;
    logic               result_valid;
    ktsm_out_t          result;
    logic               cfg_we = 0;
    logic [LIMIT_W-1:0] cfg_data = '0;
    int                 fail_count;
    int                 pending;
    int                 burst_left = 0;
    int                 sent = 0;

    keyword_table_substring_matcher u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .result_valid(result_valid), .result(result), .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    tb_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .result_valid(result_valid), .result(result), .cfg_we(cfg_we),
        .cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    initial
    begin
        #50ms;
        $display("Verification failed");
        $finish;
    end

    string vocab [] = '{"cat", "Dog", "bird", "AbC", "ab", "a", "xyz", "hello", "HeLLo"};

    task automatic send(input ktsm_kind_t k, input logic [7:0] c, input bit nc,
                        input bit lst);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 5);
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        start <= 1;
        item <= '{kind: k, ch: c, no_char: nc, last: lst};
        @(posedge clk);
        start <= 0;
        sent++;
    endtask

    task automatic send_text(input ktsm_kind_t k, input string s);
        if (s.len() == 0)
            send(k, 8'd0, 1'b1, 1'b1);
        for (int i = 0; i < s.len(); i++)
            send(k, s[i], 1'b0, i == s.len() - 1);
    endtask

    function automatic string rand_word(input int maxlen);
        string s;
        string alpha;
        int n;
        int c;
        alpha = "aAbBcC";
        n = $urandom_range(1, maxlen);
        s = "";
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                c = int'($urandom_range(1, 255));
            else
                c = int'(alpha[$urandom_range(0, 5)]);
            s = $sformatf("%s%c", s, c);
        end
        return s;
    endfunction

    task automatic drain();
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic set_limit(input logic [LIMIT_W-1:0] v);
        cfg_we <= 1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    task automatic random_phase(input int n);
        string w;
        int r;
        while (sent < n)
        begin
            r = $urandom_range(0, 9);
            w = ($urandom_range(0, 1) == 0) ? vocab[$urandom_range(0, vocab.size() - 1)]
                                           : rand_word(4);
            if (r < 3)
                send_text(KIND_ADD, w);
            else if (r < 5)
                send_text(KIND_REMOVE, w);
            else if (r < 8)
                send_text(KIND_SCAN, {rand_word(3), w, rand_word(3)});
            else
                send(ktsm_kind_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        send_text(KIND_ADD, "");
        send_text(KIND_ADD, "Cat");
        send_text(KIND_ADD, "cAT");
        send(KIND_ADD, 8'h00, 1'b0, 1'b0);
        send(KIND_ADD, 8'hFF, 1'b0, 1'b1);
        send_text(KIND_ADD, "abcdefghijklmnopqrstuvwxyz0123456789");
        send_text(KIND_SCAN, "xxCATxx");
        send_text(KIND_SCAN, "");
        send_text(KIND_REMOVE, "");
        send_text(KIND_REMOVE, "dog");
        send_text(KIND_NONE, "cat");
        send(KIND_NONE, "q", 1'b0, 1'b0);
        send(KIND_REMOVE, "x", 1'b0, 1'b0);
        send(KIND_SCAN, "y", 1'b0, 1'b1);
        for (int i = 0; i < 16; i++)
            send_text(KIND_ADD, $sformatf("k%0d", i));
        send_text(KIND_SCAN, "zzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789");
        send_text(KIND_REMOVE, "CAT");
        drain();
        set_limit(5'd0);
        send_text(KIND_SCAN, "k3");
        drain();
        set_limit(5'd3);
        random_phase(200);
        drain();
        set_limit(5'd31);
        random_phase(310);
        drain();
        set_limit(5'd1);
        random_phase(420);
        drain();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
